[design/assert_macros.svh]
// Assertion helpers shared by the RTL. Both take a clock, an active-low
// reset, a condition and a consequence. They compile to nothing under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequence must hold in the same cycle as the condition.
`define LTPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequence must hold in the cycle after the condition.
`define LTPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define LTPD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LTPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/ltpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ltpd_pkg;

  localparam logic [31:0] MAX_PAYLOAD_RST = 32'd65536;
  localparam logic [2:0]  HDR_LAST        = 3'd5;

  typedef enum logic [1:0] {
    STATUS_PAYLOAD  = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_OVERSIZE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_DEAD    = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] msg_type;
    logic [31:0] msg_length;
    logic [7:0]  payload_byte;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] max_payload;
  } cfg_item_t;

endpackage

`default_nettype wire

[design/ltpd_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface ltpd_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

[design/length_type_prefixed_deframer_top.sv]
// Length/type prefixed message deframer.
// in_chan carries the received stream, one byte per item. Each message is a
// six-byte header (32-bit little-endian length, 16-bit little-endian type)
// followed by the payload. out_chan gives one item per payload byte with the
// type, the length and a last flag, one empty-message item for a zero length,
// or one oversize error item when the length exceeds max_payload. After an
// error every later byte is swallowed until reset.
// cfg_chan writes max_payload; it is always ready and should only be written
// while the block is idle.
// A result appears on out_chan in the cycle after the byte that causes it.
// Throughput is one byte per cycle unless the receiver stalls: the header and
// payload state is updated by a single level of logic and the result goes
// into one output register. When the receiver stalls, input is still taken
// as long as the output register is free.
// Reset clears the header state, empties the output register and restores
// max_payload to 65536.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module length_type_prefixed_deframer_top (
  input  wire logic    clk,
  input  wire logic    rst_n,
  ltpd_stream_if.sink   in_chan,
  ltpd_stream_if.source out_chan,
  ltpd_stream_if.sink   cfg_chan
);

  import ltpd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0] len_r, len_nxt;
  logic [15:0] type_r, type_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] max_payload_r;

  logic        out_valid_r;
  out_item_t   out_r;

  logic        in_accept;
  logic [7:0]  b;
  logic [31:0] len_hdr;
  logic [15:0] type_hdr;
  logic        res_valid;
  out_item_t   res;

  assign in_chan.ready  = !out_valid_r || out_chan.ready;
  assign in_accept      = in_chan.valid && in_chan.ready;
  assign b              = in_chan.payload.data_byte;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_r;

  // Header assembly; the first byte of a header starts both fields afresh.
  always_comb begin
    len_hdr  = len_r;
    type_hdr = type_r;
    case (hdr_cnt_r)
      3'd0: begin
        len_hdr  = {24'd0, b};
        type_hdr = 16'd0;
      end
      3'd1: len_hdr = {len_r[31:16], b, len_r[7:0]};
      3'd2: len_hdr = {len_r[31:24], b, len_r[15:0]};
      3'd3: len_hdr = {b, len_r[23:0]};
      3'd4: type_hdr = {type_r[15:8], b};
      default: type_hdr = {b, type_r[7:0]};
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    len_nxt     = len_r;
    type_nxt    = type_r;
    rem_nxt     = rem_r;
    res_valid   = 1'b0;
    res.status       = STATUS_PAYLOAD;
    res.msg_type     = type_r;
    res.msg_length   = len_r;
    res.payload_byte = 8'd0;
    res.last         = 1'b0;
    if (in_accept) begin
      case (phase_r)
        PH_HEADER: begin
          len_nxt  = len_hdr;
          type_nxt = type_hdr;
          res.msg_type   = type_hdr;
          res.msg_length = len_hdr;
          if (hdr_cnt_r == HDR_LAST) begin
            hdr_cnt_nxt = 3'd0;
            if (len_hdr > max_payload_r) begin
              phase_nxt  = PH_DEAD;
              res_valid  = 1'b1;
              res.status = STATUS_OVERSIZE;
              res.last   = 1'b1;
            end else if (len_hdr == 32'd0) begin
              res_valid  = 1'b1;
              res.status = STATUS_EMPTY;
              res.last   = 1'b1;
            end else begin
              rem_nxt   = len_hdr;
              phase_nxt = PH_PAYLOAD;
            end
          end else begin
            hdr_cnt_nxt = hdr_cnt_r + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          rem_nxt          = rem_r - 32'd1;
          res_valid        = 1'b1;
          res.payload_byte = b;
          res.last         = (rem_r == 32'd1);
          if (rem_r == 32'd1) begin
            phase_nxt = PH_HEADER;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HEADER;
      hdr_cnt_r     <= 3'd0;
      len_r         <= 32'd0;
      type_r        <= 16'd0;
      rem_r         <= 32'd0;
      max_payload_r <= MAX_PAYLOAD_RST;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      len_r     <= len_nxt;
      type_r    <= type_nxt;
      rem_r     <= rem_nxt;
      if (cfg_chan.valid) begin
        max_payload_r <= cfg_chan.payload.max_payload;
      end
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  `LTPD_ASSERT_NEXT(a_dead_sticks, clk, rst_n, phase_r == PH_DEAD, phase_r == PH_DEAD)
  `LTPD_ASSERT_SAME(a_hdr_cnt_range, clk, rst_n, 1'b1, hdr_cnt_r <= HDR_LAST)
  `LTPD_ASSERT_SAME(a_rem_bounds, clk, rst_n,
    phase_r == PH_PAYLOAD,
    (rem_r != 32'd0) && (rem_r <= len_r))
  `LTPD_ASSERT_NEXT(a_oversize_result, clk, rst_n,
    in_accept && (phase_r == PH_HEADER) && (hdr_cnt_r == HDR_LAST) &&
      (len_r > max_payload_r),
    out_valid_r && (out_r.status == STATUS_OVERSIZE) && (phase_r == PH_DEAD))

endmodule

`default_nettype wire
